FILE: rtl/core/eatp_pkg.sv
// Package for the eigen triple product block: command codes, sequencer states,
// datapath widths and the Q16.16 saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package eatp_pkg;

    // Command field codes
    typedef enum logic [1:0] {
        CMD_LOAD_RIGHT = 2'd0,
        CMD_LOAD_LEFT  = 2'd1,
        CMD_LOAD_EIGEN = 2'd2,
        CMD_COMPUTE    = 2'd3
    } cmd_t;

    // Sequencer states, one pass per term of the inner sum
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL_R,
        ST_SAT_T,
        ST_MUL_L,
        ST_ACCUM,
        ST_DONE
    } state_t;

    localparam int VAL_W  = 32;
    localparam int MAG_W  = 33;
    localparam int OPND_W = 34;
    localparam int PROD_W = 64;
    localparam int FRAC_W = 16;

    // floor(p / 2^16), saturated to 32 signed bits
    function automatic logic signed [VAL_W-1:0] sat_q16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] shifted;
        logic signed [VAL_W-1:0]  res;
        shifted = p >>> FRAC_W;
        if (shifted[PROD_W-1:VAL_W-1] == '0 || shifted[PROD_W-1:VAL_W-1] == '1)
        begin
            res = shifted[VAL_W-1:0];
        end
        else if (p[PROD_W-1])
        begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    // a + b, saturated to 32 signed bits
    function automatic logic signed [VAL_W-1:0] sat_add(input logic signed [VAL_W-1:0] a,
                                                       input logic signed [VAL_W-1:0] b);
        logic [VAL_W:0]          sum;
        logic signed [VAL_W-1:0] res;
        sum = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (sum[VAL_W] == sum[VAL_W-1])
        begin
            res = sum[VAL_W-1:0];
        end
        else if (sum[VAL_W])
        begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/eigen_abs_matrix_triple_product.sv
// Usage:
//   Computes P = R * |diag(lambda)| * W in signed Q16.16 for a DIM x DIM system.
//   Input channel (in_valid / in_ready) takes one word per accepted cycle:
//   command selects a load of a right entry, a left entry or an eigenvalue,
//   or a compute. Loads give no output; a load whose index is not below
//   DIM is dropped. Eigenvalues are stored as magnitudes.
//   A compute emits DIM*DIM words on the output channel (out_valid /
//   out_ready) in row-major order, last set on the final one.
//   Sequencing: each term of an entry passes through the single shared
//   multiplier as fetch, R*|lambda|, saturate, times W and accumulate, and
//   each entry then has a hand-off step; in_ready stays low for the whole
//   compute, from the command until the last entry is handed off.
//   The result sits in an output register; a stall on out_ready holds the
//   sequencer at that entry's hand-off until the register is freed.
//   Reset clears the sequencer and output valid; stored entries stay undefined
//   until loaded, and a compute must only follow loads of all entries it reads.
// Depends on eatp_pkg and eatp_mul.
`timescale 1ns / 1ps

module eigen_abs_matrix_triple_product
    import eatp_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [1:0]              row_index,
    input  logic [1:0]              col_index,
    input  logic signed [VAL_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              out_row,
    output logic [1:0]              out_col,
    output logic signed [VAL_W-1:0] product_value,
    output logic                    last
);

    localparam int IDX_W = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int AW    = (DIM > 1) ? $clog2(DIM * DIM) : 1;
    localparam int DEPTH = DIM * DIM;

    // Storage
    logic signed [VAL_W-1:0] right_mem [DEPTH];
    logic signed [VAL_W-1:0] left_mem  [DEPTH];
    logic [MAG_W-1:0]        eig_mem   [DIM];

    logic signed [VAL_W-1:0] right_rd_reg;
    logic signed [VAL_W-1:0] left_rd_reg;
    logic [MAG_W-1:0]        eig_rd_reg;

    // Sequencer and datapath registers
    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        r_reg, r_next;
    logic [IDX_W-1:0]        c_reg, c_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic signed [VAL_W-1:0] acc_reg, acc_next;
    logic signed [VAL_W-1:0] term_reg, term_next;

    logic                    out_valid_reg, out_valid_next;
    logic [1:0]              out_row_reg, out_row_next;
    logic [1:0]              out_col_reg, out_col_next;
    logic signed [VAL_W-1:0] out_val_reg, out_val_next;
    logic                    out_last_reg, out_last_next;

    logic                    in_fire;
    logic                    row_ok;
    logic                    col_ok;
    logic [AW-1:0]           wr_addr;
    logic [IDX_W-1:0]        eig_wr_idx;
    logic [MAG_W-1:0]        mag;
    logic [AW-1:0]           right_rd_addr;
    logic [AW-1:0]           left_rd_addr;

    logic                    mul_en;
    logic signed [OPND_W-1:0] mul_a;
    logic signed [OPND_W-1:0] mul_b;
    logic signed [PROD_W-1:0] prod;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;

    // Load decode
    assign row_ok     = (32'(row_index) < DIM);
    assign col_ok     = (32'(col_index) < DIM);
    assign wr_addr    = AW'(32'(row_index) * DIM + 32'(col_index));
    assign eig_wr_idx = IDX_W'(row_index);
    assign mag        = value[VAL_W-1] ? (MAG_W'(0) - {1'b1, value}) : {1'b0, value};

    // Term operand addresses
    assign right_rd_addr = AW'(32'(r_reg) * DIM + 32'(k_reg));
    assign left_rd_addr  = AW'(32'(k_reg) * DIM + 32'(c_reg));

    // Memory writes and registered reads
    always_ff @(posedge clk)
    begin
        if (in_fire && command == CMD_LOAD_RIGHT && row_ok && col_ok)
        begin
            right_mem[wr_addr] <= value;
        end
        if (in_fire && command == CMD_LOAD_LEFT && row_ok && col_ok)
        begin
            left_mem[wr_addr] <= value;
        end
        if (in_fire && command == CMD_LOAD_EIGEN && row_ok)
        begin
            eig_mem[eig_wr_idx] <= mag;
        end
        right_rd_reg <= right_mem[right_rd_addr];
        left_rd_reg  <= left_mem[left_rd_addr];
        eig_rd_reg   <= eig_mem[k_reg];
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_en = 1'b0;
        mul_a  = {{(OPND_W-VAL_W){right_rd_reg[VAL_W-1]}}, right_rd_reg};
        mul_b  = {{(OPND_W-MAG_W){1'b0}}, eig_rd_reg};
        case (state_reg)
            ST_MUL_R:
            begin
                mul_en = 1'b1;
            end
            ST_MUL_L:
            begin
                mul_en = 1'b1;
                mul_a  = {{(OPND_W-VAL_W){term_reg[VAL_W-1]}}, term_reg};
                mul_b  = {{(OPND_W-VAL_W){left_rd_reg[VAL_W-1]}}, left_rd_reg};
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    eatp_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        term_reg     <= term_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    // Next state and datapath updates
    always_comb
    begin
        state_next     = state_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        k_next         = k_reg;
        acc_next       = acc_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && command == CMD_COMPUTE)
                begin
                    r_next     = '0;
                    c_next     = '0;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_MUL_R;
            end
            ST_MUL_R:
            begin
                state_next = ST_SAT_T;
            end
            ST_SAT_T:
            begin
                term_next  = sat_q16(prod);
                state_next = ST_MUL_L;
            end
            ST_MUL_L:
            begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                acc_next = sat_add(acc_reg, sat_q16(prod));
                if (k_reg == IDX_W'(DIM - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_DONE:
            begin
                // Hand the entry off once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_row_next   = 2'(r_reg);
                    out_col_next   = 2'(c_reg);
                    out_val_next   = acc_reg;
                    out_last_next  = (r_reg == IDX_W'(DIM - 1)) && (c_reg == IDX_W'(DIM - 1));
                    acc_next       = '0;
                    k_next         = '0;
                    state_next     = ST_FETCH;
                    if (c_reg == IDX_W'(DIM - 1))
                    begin
                        c_next = '0;
                        if (r_reg == IDX_W'(DIM - 1))
                        begin
                            r_next     = '0;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            r_next = r_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        c_next = c_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign out_row       = out_row_reg;
    assign out_col       = out_col_reg;
    assign product_value = out_val_reg;
    assign last          = out_last_reg;

`ifndef SYNTHESIS
    // Sequencer returns to idle with all counters cleared
    a_idle_counters: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (r_reg == '0 && c_reg == '0 && k_reg == '0))
        else $error("idle with nonzero entry counters");

    // Second product only follows saturation of the first
    a_term_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL_L |-> $past(state_reg) == ST_SAT_T)
        else $error("second multiply out of order");

    // A finished entry with a free output register is handed off at once
    a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !out_valid_reg) |=> (out_valid_reg && state_reg != ST_DONE))
        else $error("entry not handed off to free output register");
`endif

endmodule

FILE: rtl/core/eatp_mul.sv
// Shared registered signed multiplier used for both products of every term.
// Depends on eatp_pkg for operand and product widths.
`timescale 1ns / 1ps

module eatp_mul
    import eatp_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [OPND_W-1:0] a,
    input  logic signed [OPND_W-1:0] b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [2*OPND_W-1:0] full;
    logic signed [PROD_W-1:0]   prod_reg;

    // Operands stay within 2^31 in magnitude, so the low 64 bits hold the product
    assign full = a * b;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= full[PROD_W-1:0];
        end
    end

    assign prod = prod_reg;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for eigen_abs_matrix_triple_product: loads random and extreme
// Q16.16 entries, runs computes and checks every product word against its own predictor.
// Depends on eatp_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import eatp_pkg::*;

    localparam int DIM         = 4;
    localparam int N_RANDOM    = 165;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 450;
    localparam int DRAIN       = 40;
    localparam int QUIET_START = 4000;
    localparam int QUIET_END   = 9000;

    localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [VAL_W-1:0] Q_ONE = 32'sh00010000;

    // One input word, or a marker that makes the sender wait for all results
    typedef struct {
        cmd_t                    cmd;
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [VAL_W-1:0] val;
        bit                      barrier;
    } in_word_t;

    typedef struct {
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [VAL_W-1:0] val;
        logic                    is_last;
    } product_word_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              command = '0;
    logic [1:0]              row_index = '0;
    logic [1:0]              col_index = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [1:0]              out_row;
    logic [1:0]              out_col;
    logic signed [VAL_W-1:0] product_value;
    logic                    last;

    in_word_t      word_q[$];
    product_word_t product_q[$];

    // Predictor copy of the stored operands
    logic signed [VAL_W-1:0] right_m [DIM*DIM];
    logic signed [VAL_W-1:0] left_m  [DIM*DIM];
    logic signed [VAL_W-1:0] eig_m   [DIM];

    int cycle_count = 0;
    int words_sent = 0;
    int computes_sent = 0;
    int results_seen = 0;
    int error_count = 0;
    int hold_cnt = 0;
    wire quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

    eigen_abs_matrix_triple_product #(.DIM(DIM)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .row_index     (row_index),
        .col_index     (col_index),
        .value         (value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_row       (out_row),
        .out_col       (out_col),
        .product_value (product_value),
        .last          (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic longint clamp32(input longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    // P[r][c] = sum_k R[r][k] * |lambda_k| * W[k][c], floored and saturated per step
    function automatic logic signed [VAL_W-1:0] triple_entry(input int r, input int c);
        longint acc;
        longint mag;
        longint t;
        longint u;
        acc = 0;
        for (int k = 0; k < DIM; k++)
        begin
            mag = longint'(eig_m[k]);
            if (mag < 0)
            begin
                mag = -mag;
            end
            t   = clamp32((longint'(right_m[r*DIM+k]) * mag) >>> FRAC_W);
            u   = clamp32((t * longint'(left_m[k*DIM+c])) >>> FRAC_W);
            acc = clamp32(acc + u);
        end
        return acc[VAL_W-1:0];
    endfunction

    // Update stored operands, or queue the whole product matrix on a compute
    task automatic apply_word(input in_word_t w);
        product_word_t p;
        case (w.cmd)
            CMD_LOAD_RIGHT: right_m[w.row*DIM+w.col] = w.val;
            CMD_LOAD_LEFT:  left_m[w.row*DIM+w.col]  = w.val;
            CMD_LOAD_EIGEN: eig_m[w.row]             = w.val;
            default:
            begin
                for (int r = 0; r < DIM; r++)
                begin
                    for (int c = 0; c < DIM; c++)
                    begin
                        p.row     = r[1:0];
                        p.col     = c[1:0];
                        p.val     = triple_entry(r, c);
                        p.is_last = (r == DIM-1) && (c == DIM-1);
                        product_q.push_back(p);
                    end
                end
            end
        endcase
    endtask

    task automatic add_word(input cmd_t cmd, input int row, input int col,
                            input logic signed [VAL_W-1:0] val);
        in_word_t w;
        w.cmd     = cmd;
        w.row     = row[1:0];
        w.col     = col[1:0];
        w.val     = val;
        w.barrier = 1'b0;
        word_q.push_back(w);
    endtask

    task automatic add_barrier();
        in_word_t w;
        w.cmd     = CMD_COMPUTE;
        w.row     = '0;
        w.col     = '0;
        w.val     = '0;
        w.barrier = 1'b1;
        word_q.push_back(w);
    endtask

    // Mix of corner values, full-range words and small values that stay unsaturated
    function automatic logic signed [VAL_W-1:0] rand_q16();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(3))
            0:
            begin
                case ($urandom_range(4))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = '0;
                    3:       v = -32'sd1;
                    default: v = Q_ONE;
                endcase
            end
            1:       v = $urandom;
            default: v = $signed($urandom_range(0, 2**19)) - 32'sd262144;
        endcase
        return v;
    endfunction

    // Sender: pops pending words, holds each until accepted
    always @(posedge clk or negedge rst_n)
    begin : sender
        in_word_t w;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                w.cmd     = cmd_t'(command);
                w.row     = row_index;
                w.col     = col_index;
                w.val     = value;
                w.barrier = 1'b0;
                apply_word(w);
                words_sent++;
                if (w.cmd == CMD_COMPUTE)
                begin
                    computes_sent++;
                end
            end
            if (!in_valid || in_ready)
            begin
                if (word_q.size() != 0 && word_q[0].barrier)
                begin
                    if (product_q.size() == 0)
                    begin
                        void'(word_q.pop_front());
                    end
                    in_valid <= 1'b0;
                end
                else if (word_q.size() != 0 && (quiet || $urandom_range(99) >= 8))
                begin
                    w = word_q.pop_front();
                    in_valid  <= 1'b1;
                    command   <= w.cmd;
                    row_index <= w.row;
                    col_index <= w.col;
                    value     <= w.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_cnt  <= 0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (out_valid && out_ready && (results_seen == 20 || results_seen == 200))
        begin
            hold_cnt  <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Monitor: compare each accepted word with the oldest expected entry
    always @(posedge clk)
    begin : monitor
        product_word_t p;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (product_q.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word row=%0d col=%0d value=%0d last=%0b",
                         $time, out_row, out_col, product_value, last);
            end
            else
            begin
                p = product_q.pop_front();
                if (out_row !== p.row || out_col !== p.col ||
                    product_value !== p.val || last !== p.is_last)
                begin
                    error_count++;
                    $display("%0t: mismatch expected row=%0d col=%0d value=%0d last=%0b",
                             $time, p.row, p.col, p.val, p.is_last);
                    $display("%0t:          actual   row=%0d col=%0d value=%0d last=%0b",
                             $time, out_row, out_col, product_value, last);
                end
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        // Every entry is written before the first compute
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                add_word(CMD_LOAD_RIGHT, r, c, rand_q16());
                add_word(CMD_LOAD_LEFT, r, c, rand_q16());
            end
            add_word(CMD_LOAD_EIGEN, r, $urandom_range(3), rand_q16());
        end
        add_word(CMD_COMPUTE, 0, 0, '0);

        // Most negative eigenvalues (magnitude 2^31) against full-scale entries: saturation
        for (int k = 0; k < DIM; k++)
        begin
            add_word(CMD_LOAD_EIGEN, k, 3, Q_MIN);
        end
        add_word(CMD_LOAD_RIGHT, 0, 0, Q_MAX);
        add_word(CMD_LOAD_RIGHT, 1, 0, Q_MIN);
        add_word(CMD_LOAD_LEFT, 0, 0, Q_MAX);
        add_word(CMD_LOAD_LEFT, 0, 1, Q_MIN);
        add_word(CMD_COMPUTE, 3, 3, Q_MAX);

        // Tiny negative values: floor truncation toward minus infinity
        add_word(CMD_LOAD_EIGEN, 1, 0, -32'sd1);
        add_word(CMD_LOAD_EIGEN, 2, 0, Q_ONE);
        add_word(CMD_LOAD_EIGEN, 3, 0, '0);
        add_word(CMD_LOAD_RIGHT, 2, 3, -32'sd1);
        add_word(CMD_LOAD_LEFT, 3, 2, 32'sd1);
        add_word(CMD_COMPUTE, 1, 2, '0);

        // Drain, then two computes back to back on the same operands
        add_barrier();
        add_word(CMD_COMPUTE, 2, 1, -32'sd1);
        add_word(CMD_COMPUTE, 0, 3, Q_MIN);

        // Random traffic, mostly loads with a compute every so often
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 2)
            begin
                add_barrier();
            end
            if ($urandom_range(99) < 12)
            begin
                add_word(CMD_COMPUTE, $urandom_range(3), $urandom_range(3), $urandom);
            end
            else
            begin
                add_word(cmd_t'($urandom_range(2)), $urandom_range(3), $urandom_range(3),
                         rand_q16());
            end
        end
        add_word(CMD_COMPUTE, 0, 0, '0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Poll each cycle until every word is sent and every product checked
        while (word_q.size() != 0 || in_valid || product_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN) @(posedge clk);

        $display("Sent %0d words including %0d computes; checked %0d product words",
                 words_sent, computes_sent, results_seen);
        $display("Covered saturation, floor truncation, output hold-off and idle gaps");
        if (error_count == 0 && product_q.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
